FILE: rtl/core/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// shared constants, codes and handshake types for the timer slot table
// ----------------------------------------------------------------------------
package mst_pkg;

   // table geometry
   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int ID_BITS   = 8;

   // field widths of the ports
   localparam int ACTION_W = 3;
   localparam int TID_W    = 8;
   localparam int PERIOD_W = 16;
   localparam int KIND_W   = 3;
   localparam int INDEX_W  = 4;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ADD     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SERVICE = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] RES_ADDED      = 3'd0;
   localparam logic [KIND_W-1:0] RES_REJECTED   = 3'd1;
   localparam logic [KIND_W-1:0] RES_STOPPED    = 3'd2;
   localparam logic [KIND_W-1:0] RES_STOP_MISS  = 3'd3;
   localparam logic [KIND_W-1:0] RES_RESTARTED  = 3'd4;
   localparam logic [KIND_W-1:0] RES_RESTART_MISS = 3'd5;
   localparam logic [KIND_W-1:0] RES_FIRED      = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture a new command, rewind the slot walk
      logic step;   // process the current slot and advance
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;     // current slot produces a result
      logic finish;   // current slot ends the command
      logic out_free; // output register can take a result this cycle
   } dp_status_type;

endpackage

FILE: rtl/core/mst_ctrl.sv
// ----------------------------------------------------------------------------
// mst_ctrl
// command sequencer: accepts a command, then walks the slots, unless a result waits on a stalled output, one per cycle
// ----------------------------------------------------------------------------
module mst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mst_pkg::dp_status_type status,
   output mst_pkg::ctl_cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff;
   logic state_in;

   // input is taken only between commands
   assign req_stall = (state_ff != ST_IDLE);

   // step when the slot needs no result or the output register has room
   always_comb begin
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = !status.emit || status.out_free;
            if (cmd.step && status.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/mst_datapath.sv
// ----------------------------------------------------------------------------
// mst_datapath
// slot storage, per-slot command logic and the result register
// ----------------------------------------------------------------------------
module mst_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mst_pkg::ctl_cmd_type                cmd,
   output mst_pkg::dp_status_type              status,
   input  logic [mst_pkg::ACTION_W-1:0]        req_action,
   input  logic [mst_pkg::TID_W-1:0]           req_timer_id,
   input  logic [mst_pkg::PERIOD_W-1:0]        req_period,
   input  logic                                req_continuous,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mst_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [mst_pkg::INDEX_W-1:0]         rsp_slot_index,
   output logic [mst_pkg::TID_W-1:0]           rsp_fired_id,
   output logic                                rsp_last_item
);

   // slot table
   logic [mst_pkg::ID_BITS-1:0]  owner_ff  [mst_pkg::SLOTS];
   logic [mst_pkg::PERIOD_W-1:0] remain_ff [mst_pkg::SLOTS];
   logic [mst_pkg::PERIOD_W-1:0] reload_ff [mst_pkg::SLOTS];
   logic                         repeat_ff [mst_pkg::SLOTS];

   // captured command and walk position
   logic [mst_pkg::ACTION_W-1:0]  act_ff;
   logic [mst_pkg::ID_BITS-1:0]   id_ff;
   logic [mst_pkg::PERIOD_W-1:0]  period_ff;
   logic                          cont_ff;
   logic [mst_pkg::SLOT_BITS-1:0] idx_ff;

   // result register
   logic                         out_valid_ff;
   logic [mst_pkg::KIND_W-1:0]   out_kind_ff;
   logic [mst_pkg::INDEX_W-1:0]  out_index_ff;
   logic [mst_pkg::TID_W-1:0]    out_id_ff;
   logic                         out_last_ff;

   logic [mst_pkg::ID_BITS-1:0]  cur_owner;
   logic [mst_pkg::PERIOD_W-1:0] cur_remain;
   logic [mst_pkg::PERIOD_W-1:0] cur_reload;
   logic                         cur_repeat;
   logic                         last_slot;
   logic                         hit;
   logic                         armed_above;
   logic [mst_pkg::KIND_W-1:0]   res_kind;
   logic [mst_pkg::TID_W-1:0]    res_id;
   logic                         res_last;
   logic                         do_emit;

   // slot under the walk
   assign cur_owner  = owner_ff[idx_ff];
   assign cur_remain = remain_ff[idx_ff];
   assign cur_reload = reload_ff[idx_ff];
   assign cur_repeat = repeat_ff[idx_ff];
   assign last_slot  = (idx_ff == mst_pkg::SLOT_BITS'(mst_pkg::SLOTS - 1));

   // any expired slot beyond the current one, for the last mark on service
   always_comb begin
      armed_above = 1'b0;
      for (int i = 0; i < mst_pkg::SLOTS; i++) begin
         if ((i > int'(idx_ff)) && (owner_ff[i] != '0) && (remain_ff[i] == '0)) begin
            armed_above = 1'b1;
         end
      end
   end

   // per-slot decision
   always_comb begin
      hit      = 1'b0;
      do_emit  = 1'b0;
      res_kind = mst_pkg::RES_REJECTED;
      res_id   = mst_pkg::TID_W'(id_ff);
      res_last = 1'b1;
      status.finish = last_slot;
      case (act_ff)
         mst_pkg::ACT_ADD: begin
            hit      = (id_ff != '0) && (cur_owner == '0);
            do_emit  = hit || last_slot;
            res_kind = hit ? mst_pkg::RES_ADDED : mst_pkg::RES_REJECTED;
            status.finish = do_emit;
         end
         mst_pkg::ACT_STOP: begin
            hit      = (id_ff != '0) && (cur_owner == id_ff);
            do_emit  = hit || last_slot;
            res_kind = hit ? mst_pkg::RES_STOPPED : mst_pkg::RES_STOP_MISS;
            status.finish = do_emit;
         end
         mst_pkg::ACT_RESTART: begin
            hit      = (id_ff != '0) && (cur_owner == id_ff);
            do_emit  = hit || last_slot;
            res_kind = hit ? mst_pkg::RES_RESTARTED : mst_pkg::RES_RESTART_MISS;
            status.finish = do_emit;
         end
         mst_pkg::ACT_SERVICE: begin
            hit      = (cur_owner != '0) && (cur_remain == '0);
            do_emit  = hit;
            res_kind = mst_pkg::RES_FIRED;
            res_id   = mst_pkg::TID_W'(cur_owner);
            res_last = !armed_above;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      status.emit     = do_emit;
      status.out_free = !out_valid_ff || !rsp_stall;
   end

   // command capture and walk counter
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= req_action;
         id_ff     <= req_timer_id[mst_pkg::ID_BITS-1:0];
         period_ff <= req_period;
         cont_ff   <= req_continuous;
         idx_ff    <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // slot table update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mst_pkg::SLOTS; i++) begin
            owner_ff[i]  <= '0;
            remain_ff[i] <= '0;
            reload_ff[i] <= '0;
            repeat_ff[i] <= 1'b0;
         end
      end else if (cmd.step) begin
         case (act_ff)
            mst_pkg::ACT_ADD: begin
               if (hit) begin
                  owner_ff[idx_ff]  <= id_ff;
                  remain_ff[idx_ff] <= period_ff;
                  reload_ff[idx_ff] <= period_ff;
                  repeat_ff[idx_ff] <= cont_ff;
               end
            end
            mst_pkg::ACT_STOP: begin
               if (hit) begin
                  owner_ff[idx_ff]  <= '0;
                  remain_ff[idx_ff] <= '0;
                  reload_ff[idx_ff] <= '0;
                  repeat_ff[idx_ff] <= 1'b0;
               end
            end
            mst_pkg::ACT_RESTART: begin
               if (hit) begin
                  remain_ff[idx_ff] <= cur_reload;
               end
            end
            mst_pkg::ACT_TICK: begin
               if (cur_remain != '0) begin
                  remain_ff[idx_ff] <= cur_remain - 1'b1;
               end
            end
            mst_pkg::ACT_SERVICE: begin
               if (hit) begin
                  if (cur_repeat) begin
                     remain_ff[idx_ff] <= cur_reload;
                  end else begin
                     owner_ff[idx_ff]  <= '0;
                     remain_ff[idx_ff] <= '0;
                     reload_ff[idx_ff] <= '0;
                     repeat_ff[idx_ff] <= 1'b0;
                  end
               end
            end
            default: begin
               owner_ff[idx_ff] <= cur_owner;
            end
         endcase
      end
   end

   // result register: loads when a result is produced, empties on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.step && do_emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && do_emit) begin
         out_kind_ff  <= res_kind;
         out_index_ff <= hit ? mst_pkg::INDEX_W'(idx_ff) : '0;
         out_id_ff    <= res_id;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = out_kind_ff;
   assign rsp_slot_index  = out_index_ff;
   assign rsp_fired_id    = out_id_ff;
   assign rsp_last_item   = out_last_ff;

endmodule

FILE: rtl/core/multi_slot_software_timer_table.sv
// A table of 16 timer slots driven by commands: add, stop, restart, tick and
// service. Every command is taken in, then walks the slot table once, one slot
// per clock while the slot needs no result or the output register has room;
// add, stop and restart end early at the slot they act on. Service delivers
// one fired result per expired slot in slot order, the final one marked with
// last_item; while the output is stalled the walk waits at the slot that has
// a result. A new command is taken once the previous walk has ended, even if
// its final result is still waiting in the output register.
// ----------------------------------------------------------------------------
// multi_slot_software_timer_table
// top level: command sequencer plus slot table datapath
// ----------------------------------------------------------------------------
module multi_slot_software_timer_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mst_pkg::ACTION_W-1:0]       req_action,
   input  logic [mst_pkg::TID_W-1:0]          req_timer_id,
   input  logic [mst_pkg::PERIOD_W-1:0]       req_period,
   input  logic                               req_continuous,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mst_pkg::KIND_W-1:0]         rsp_result_kind,
   output logic [mst_pkg::INDEX_W-1:0]        rsp_slot_index,
   output logic [mst_pkg::TID_W-1:0]          rsp_fired_id,
   output logic                               rsp_last_item
);

   mst_pkg::ctl_cmd_type   cmd;
   mst_pkg::dp_status_type status;

   // sequencer
   mst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // slot table and result register
   mst_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_timer_id    (req_timer_id),
      .req_period      (req_period),
      .req_continuous  (req_continuous),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last_item   (rsp_last_item)
   );

endmodule

FILE: verif/timer_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_table_checker
// watches both channels of the timer slot table, keeps its own copy of the
// slot table, predicts the reports of every accepted command and compares
// each report transfer with the oldest prediction
// ----------------------------------------------------------------------------
module timer_table_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [mst_pkg::ACTION_W-1:0] req_action,
   input  logic [mst_pkg::TID_W-1:0]    req_timer_id,
   input  logic [mst_pkg::PERIOD_W-1:0] req_period,
   input  logic                         req_continuous,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [mst_pkg::KIND_W-1:0]   rsp_result_kind,
   input  logic [mst_pkg::INDEX_W-1:0]  rsp_slot_index,
   input  logic [mst_pkg::TID_W-1:0]    rsp_fired_id,
   input  logic                         rsp_last_item,
   output int                           fail_count,
   output int                           reports_pending
);

   typedef struct packed {
      logic [mst_pkg::KIND_W-1:0]  kind;
      logic [mst_pkg::INDEX_W-1:0] slot;
      logic [mst_pkg::TID_W-1:0]   tid;
      logic                        last;
   } slot_report_type;

   // predicted reports, oldest first
   slot_report_type pending_reports[$];
   slot_report_type seen_report;

   // shadow copy of the slot table
   logic [mst_pkg::TID_W-1:0]    owner_tab  [mst_pkg::SLOTS];
   logic [mst_pkg::PERIOD_W-1:0] count_tab  [mst_pkg::SLOTS];
   logic [mst_pkg::PERIOD_W-1:0] reload_tab [mst_pkg::SLOTS];
   logic                         cont_tab   [mst_pkg::SLOTS];

   function automatic void push_report(input logic [mst_pkg::KIND_W-1:0] kind,
                                       input logic [mst_pkg::INDEX_W-1:0] slot,
                                       input logic [mst_pkg::TID_W-1:0] tid,
                                       input logic last);
      slot_report_type rep;
      rep.kind = kind;
      rep.slot = slot;
      rep.tid  = tid;
      rep.last = last;
      pending_reports.push_back(rep);
   endfunction

   function automatic void clear_slot(input int s);
      owner_tab[s]  = '0;
      count_tab[s]  = '0;
      reload_tab[s] = '0;
      cont_tab[s]   = 1'b0;
   endfunction

   // lowest slot owned by tid, SLOTS when none or tid is null
   function automatic int lowest_slot_of(input logic [mst_pkg::TID_W-1:0] tid);
      int hit;
      hit = mst_pkg::SLOTS;
      if (tid != '0)
         for (int k = mst_pkg::SLOTS - 1; k >= 0; k--)
            if (owner_tab[k] == tid) hit = k;
      return hit;
   endfunction

   // apply one command to the shadow table and queue its reports
   task automatic run_table_command(input logic [mst_pkg::ACTION_W-1:0] act,
                                    input logic [mst_pkg::TID_W-1:0] tid,
                                    input logic [mst_pkg::PERIOD_W-1:0] per,
                                    input logic cont);
      int s;
      int last_fire;
      case (act)
         mst_pkg::ACT_ADD: begin
            s = mst_pkg::SLOTS;
            if (tid != '0)
               for (int k = mst_pkg::SLOTS - 1; k >= 0; k--)
                  if (owner_tab[k] == '0) s = k;
            if (s == mst_pkg::SLOTS) begin
               push_report(mst_pkg::RES_REJECTED, '0, tid, 1'b1);
            end else begin
               owner_tab[s]  = tid;
               count_tab[s]  = per;
               reload_tab[s] = per;
               cont_tab[s]   = cont;
               push_report(mst_pkg::RES_ADDED, mst_pkg::INDEX_W'(s), tid, 1'b1);
            end
         end
         mst_pkg::ACT_STOP: begin
            s = lowest_slot_of(tid);
            if (s == mst_pkg::SLOTS) begin
               push_report(mst_pkg::RES_STOP_MISS, '0, tid, 1'b1);
            end else begin
               clear_slot(s);
               push_report(mst_pkg::RES_STOPPED, mst_pkg::INDEX_W'(s), tid, 1'b1);
            end
         end
         mst_pkg::ACT_RESTART: begin
            s = lowest_slot_of(tid);
            if (s == mst_pkg::SLOTS) begin
               push_report(mst_pkg::RES_RESTART_MISS, '0, tid, 1'b1);
            end else begin
               count_tab[s] = reload_tab[s];
               push_report(mst_pkg::RES_RESTARTED, mst_pkg::INDEX_W'(s), tid, 1'b1);
            end
         end
         mst_pkg::ACT_TICK: begin
            for (int k = 0; k < mst_pkg::SLOTS; k++)
               if (count_tab[k] != '0) count_tab[k] = count_tab[k] - 1'b1;
         end
         mst_pkg::ACT_SERVICE: begin
            // expiry of one slot never changes another, so find the final one first
            last_fire = -1;
            for (int k = 0; k < mst_pkg::SLOTS; k++)
               if (owner_tab[k] != '0 && count_tab[k] == '0) last_fire = k;
            for (int k = 0; k < mst_pkg::SLOTS; k++) begin
               if (owner_tab[k] != '0 && count_tab[k] == '0) begin
                  push_report(mst_pkg::RES_FIRED, mst_pkg::INDEX_W'(k), owner_tab[k],
                              k == last_fire);
                  // one-shot frees its own slot, continuous reloads
                  if (cont_tab[k]) count_tab[k] = reload_tab[k];
                  else clear_slot(k);
               end
            end
         end
         default: ;
      endcase
   endtask

   // compare report transfers, then predict from command transfers
   always @(posedge clock) begin
      if (reset) begin
         pending_reports.delete();
         for (int k = 0; k < mst_pkg::SLOTS; k++) clear_slot(k);
         fail_count = 0;
         reports_pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected report: kind %0d slot %0d id %0d last %0d",
                      rsp_result_kind, rsp_slot_index, rsp_fired_id, rsp_last_item);
               fail_count++;
            end else begin
               seen_report = pending_reports.pop_front();
               if (rsp_result_kind !== seen_report.kind) begin
                  $error("result_kind: expected %0d, actual %0d",
                         seen_report.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_slot_index !== seen_report.slot) begin
                  $error("slot_index: expected %0d, actual %0d",
                         seen_report.slot, rsp_slot_index);
                  fail_count++;
               end
               if (rsp_fired_id !== seen_report.tid) begin
                  $error("fired_id: expected %0d, actual %0d",
                         seen_report.tid, rsp_fired_id);
                  fail_count++;
               end
               if (rsp_last_item !== seen_report.last) begin
                  $error("last_item: expected %0d, actual %0d",
                         seen_report.last, rsp_last_item);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            run_table_command(req_action, req_timer_id, req_period, req_continuous);
         reports_pending <= pending_reports.size();
      end
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the timer slot table: a short directed run over
// the corner cases, then random command streams with random gaps and report
// stalls; checking is done by the checker instance beside the block
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_ITEMS = 280;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic [mst_pkg::ACTION_W-1:0] req_action     = mst_pkg::ACT_TICK;
   logic [mst_pkg::TID_W-1:0]    req_timer_id   = '0;
   logic [mst_pkg::PERIOD_W-1:0] req_period     = '0;
   logic                         req_continuous = 1'b0;
   logic                         rsp_stall      = 1'b0;
   logic                         quiet          = 1'b0;

   logic                         req_stall;
   logic                         rsp_valid;
   logic [mst_pkg::KIND_W-1:0]   rsp_result_kind;
   logic [mst_pkg::INDEX_W-1:0]  rsp_slot_index;
   logic [mst_pkg::TID_W-1:0]    rsp_fired_id;
   logic                         rsp_last_item;

   int fail_count;
   int reports_pending;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   multi_slot_software_timer_table DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_timer_id    (req_timer_id),
      .req_period      (req_period),
      .req_continuous  (req_continuous),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last_item   (rsp_last_item)
   );

   timer_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_timer_id    (req_timer_id),
      .req_period      (req_period),
      .req_continuous  (req_continuous),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_fired_id    (rsp_fired_id),
      .rsp_last_item   (rsp_last_item),
      .fail_count      (fail_count),
      .reports_pending (reports_pending)
   );

   // report side stalls at random except in the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 14);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // one command transfer, with an occasional gap ahead of it
   task automatic send_cmd(input logic [mst_pkg::ACTION_W-1:0] act,
                           input logic [mst_pkg::TID_W-1:0] tid,
                           input logic [mst_pkg::PERIOD_W-1:0] per,
                           input logic cont);
      if (!quiet && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_timer_id   <= tid;
      req_period     <= per;
      req_continuous <= cont;
      // stall is stable by the falling edge
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   initial begin
      logic [mst_pkg::ACTION_W-1:0] act;
      logic [mst_pkg::TID_W-1:0]    tid;
      logic [mst_pkg::PERIOD_W-1:0] per;
      int                           pick;
      int                           add_w;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table: no reports
      send_cmd(mst_pkg::ACT_SERVICE, 8'h00, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_TICK,    8'h00, 16'h0000, 1'b0);
      // null id is rejected
      send_cmd(mst_pkg::ACT_ADD,     8'h00, 16'hFFFF, 1'b1);
      // continuous with zero reload, longest period, duplicate ids
      send_cmd(mst_pkg::ACT_ADD,     8'hFF, 16'h0000, 1'b1);
      send_cmd(mst_pkg::ACT_ADD,     8'h01, 16'hFFFF, 1'b0);
      send_cmd(mst_pkg::ACT_ADD,     8'hAA, 16'h0002, 1'b0);
      send_cmd(mst_pkg::ACT_ADD,     8'hAA, 16'h0000, 1'b0);
      // one-shot in the higher duplicate slot frees only that slot
      send_cmd(mst_pkg::ACT_SERVICE, 8'h00, 16'h0000, 1'b0);
      // null ids on stop and restart, and an unknown id on stop
      send_cmd(mst_pkg::ACT_STOP,    8'h00, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_RESTART, 8'h00, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_STOP,    8'h55, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_TICK,    8'h00, 16'hFFFF, 1'b1);
      send_cmd(mst_pkg::ACT_RESTART, 8'hAA, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_TICK,    8'h00, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_TICK,    8'h00, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_SERVICE, 8'h00, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_RESTART, 8'hFF, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_STOP,    8'h01, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_ADD,     8'h55, 16'h0005, 1'b1);
      // unused action codes are ignored
      send_cmd(mst_pkg::ACT_SERVICE + 3'd1, 8'hAA, 16'h5A5A, 1'b1);
      send_cmd(mst_pkg::ACT_SERVICE + 3'd3, 8'hFF, 16'hFFFF, 1'b1);
      send_cmd(mst_pkg::ACT_STOP,    8'hFF, 16'h0000, 1'b0);
      send_cmd(mst_pkg::ACT_SERVICE, 8'h00, 16'h0000, 1'b0);

      // random commands: add-heavy first to fill the table, then mixed
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet <= (n >= 120 && n < 200);
         add_w = (n < 70) ? 55 : 30;
         pick = $urandom_range(0, 99);
         if (pick < add_w) act = mst_pkg::ACT_ADD;
         else if (pick < add_w + 13) act = mst_pkg::ACT_STOP;
         else if (pick < add_w + 25) act = mst_pkg::ACT_RESTART;
         else if (pick < add_w + 47) act = mst_pkg::ACT_TICK;
         else if (pick < 98) act = mst_pkg::ACT_SERVICE;
         else act = mst_pkg::ACT_SERVICE + mst_pkg::ACTION_W'($urandom_range(1, 3));

         // ids mostly from a small pool so stop and restart find their slot
         pick = $urandom_range(0, 99);
         if (pick < 78) tid = mst_pkg::TID_W'($urandom_range(1, 6));
         else if (pick < 90) tid = mst_pkg::TID_W'($urandom_range(0, 255));
         else if (pick < 95) tid = '0;
         else tid = 8'hFF;

         // short periods so slots expire often
         pick = $urandom_range(0, 99);
         if (pick < 70) per = mst_pkg::PERIOD_W'($urandom_range(0, 4));
         else if (pick < 85) per = mst_pkg::PERIOD_W'($urandom_range(5, 40));
         else if (pick < 95) per = mst_pkg::PERIOD_W'($urandom);
         else per = 16'hFFFF;

         send_cmd(act, tid, per, 1'($urandom_range(0, 1)));
      end
      req_valid <= 1'b0;
      quiet <= 1'b0;

      // drain the reports, then let any walk still running finish
      do @(negedge clock); while (reports_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
